[src/dtoi_pkg.sv]
// ----------------------------------------------------------------------------
// Decimal text to int64 package
// Shared payload types, status and mode codes, character constants, control
// bundles between the parser's units and the power-of-ten table.
// ----------------------------------------------------------------------------
`default_nettype none

package dtoi_pkg;

   // Width of byte positions and counts within one chunk (0 to 16).
   localparam int POS_W = 5;

   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_NINE  = 8'h39;
   localparam logic [7:0] ASCII_MINUS = 8'h2D;

   localparam logic [15:0] SPILL_MAX = 16'hFFFF;

   localparam logic [1:0] MODE_SPILL  = 2'd0;
   localparam logic [1:0] MODE_STRICT = 2'd1;
   localparam logic [1:0] MODE_SIGNED = 2'd2;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_EMPTY     = 3'd1,
      STATUS_NO_DIGITS = 3'd2,
      STATUS_TOO_MANY  = 3'd3,
      STATUS_OVERFLOW  = 3'd4
   } status_type;

   typedef struct packed {
      logic [63:0] chars_low;
      logic [63:0] chars_high;
      logic [4:0]  valid_count;
      logic        starts_number;
   } req_type;

   typedef struct packed {
      logic [63:0] value;
      logic [15:0] dropped_digits;
      logic [4:0]  chars_used;
      logic [2:0]  status;
   } rsp_type;

   // Controls for the byte lanes: scan fields classify, term fields weight.
   typedef struct packed {
      logic             load_term;
      logic [POS_W-1:0] scan_n;
      logic [POS_W-1:0] scan_first;
      logic [POS_W-1:0] term_first;
      logic [POS_W-1:0] term_kept;
   } lane_ctrl_type;

   typedef struct packed {
      logic load_part;
      logic load_sum;
   } merge_ctrl_type;

   typedef struct packed {
      logic load_ops;
      logic step0;
      logic step1;
      logic step2;
   } fold_ctrl_type;

   function automatic logic [63:0] pow10(input logic [POS_W-1:0] e);
      logic [63:0] p;
      case (e)
         5'd0:    p = 64'd1;
         5'd1:    p = 64'd10;
         5'd2:    p = 64'd100;
         5'd3:    p = 64'd1000;
         5'd4:    p = 64'd10000;
         5'd5:    p = 64'd100000;
         5'd6:    p = 64'd1000000;
         5'd7:    p = 64'd10000000;
         5'd8:    p = 64'd100000000;
         5'd9:    p = 64'd1000000000;
         5'd10:   p = 64'd10000000000;
         5'd11:   p = 64'd100000000000;
         5'd12:   p = 64'd1000000000000;
         5'd13:   p = 64'd10000000000000;
         5'd14:   p = 64'd100000000000000;
         5'd15:   p = 64'd1000000000000000;
         5'd16:   p = 64'd10000000000000000;
         5'd17:   p = 64'd100000000000000000;
         5'd18:   p = 64'd1000000000000000000;
         5'd19:   p = 64'd10000000000000000000;
         default: p = 64'd0;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

[src/dtoi_lane.sv]
// ----------------------------------------------------------------------------
// Decimal text to int64 byte lane
// Classifies one chunk byte and registers its digit weighted by the power of
// ten that its place among the kept digits calls for.
// ----------------------------------------------------------------------------
`default_nettype none

module dtoi_lane #(
   parameter int LANE = 0
) (
   input  wire logic                  clock,
   input  wire logic [7:0]            chr,
   input  wire dtoi_pkg::lane_ctrl_type ctrl,
   output logic                       ok,
   output logic [63:0]                term
);

   localparam int PW = dtoi_pkg::POS_W;
   localparam logic [PW-1:0] IDX = PW'(LANE);

   logic              is_digit;
   logic              keep;
   logic [PW-1:0]     kept_end;
   logic [PW-1:0]     weight;
   logic [63:0]       weight_pow;
   logic [63:0]       scaled;
   logic [63:0]       term_ff;
   logic [63:0]       term_in;

   assign is_digit = chr inside {[dtoi_pkg::ASCII_ZERO:dtoi_pkg::ASCII_NINE]};

   // Positions before the first digit (a leading minus) never stop the scan.
   assign ok = (IDX < ctrl.scan_first) || ((IDX < ctrl.scan_n) && is_digit);

   assign kept_end   = ctrl.term_first + ctrl.term_kept;
   assign keep       = (IDX >= ctrl.term_first) && (IDX < kept_end);
   assign weight     = kept_end - IDX - PW'(1);
   assign weight_pow = dtoi_pkg::pow10(weight);

   // Digit times power of ten as a four-term shift-add.
   assign scaled = (chr[0] ? weight_pow         : 64'd0) +
                   (chr[1] ? (weight_pow << 1)  : 64'd0) +
                   (chr[2] ? (weight_pow << 2)  : 64'd0) +
                   (chr[3] ? (weight_pow << 3)  : 64'd0);

   always_comb begin
      term_in = term_ff;
      if (ctrl.load_term) begin
         term_in = keep ? scaled : 64'd0;
      end
   end

   always_ff @(posedge clock) begin
      term_ff <= term_in;
   end

   assign term = term_ff;

endmodule

`default_nettype wire

[src/dtoi_merge.sv]
// ----------------------------------------------------------------------------
// Decimal text to int64 lane merge
// Two-level registered adder tree that sums the weighted lane digits into
// the value of the chunk's kept digits.
// ----------------------------------------------------------------------------
`default_nettype none

module dtoi_merge #(
   parameter int CHUNK_BYTES = 16
) (
   input  wire logic                              clock,
   input  wire dtoi_pkg::merge_ctrl_type          ctrl,
   input  wire logic [CHUNK_BYTES-1:0][63:0]      terms,
   output logic [63:0]                            sum
);

   localparam int GROUPS = (CHUNK_BYTES + 3) / 4;

   logic [GROUPS-1:0][63:0] part_ff;
   logic [GROUPS-1:0][63:0] part_in;
   logic [63:0]             sum_ff;
   logic [63:0]             sum_in;

   always_comb begin
      logic [63:0] grp;
      logic [63:0] total;
      total = 64'd0;
      for (int g = 0; g < GROUPS; g++) begin
         grp = 64'd0;
         for (int j = 0; j < 4; j++) begin
            if (g * 4 + j < CHUNK_BYTES) begin
               grp = grp + terms[g * 4 + j];
            end
         end
         part_in[g] = ctrl.load_part ? grp : part_ff[g];
         total = total + part_ff[g];
      end
      sum_in = ctrl.load_sum ? total : sum_ff;
   end

   always_ff @(posedge clock) begin
      part_ff <= part_in;
      sum_ff  <= sum_in;
   end

   assign sum = sum_ff;

endmodule

`default_nettype wire

[src/dtoi_fold.sv]
// ----------------------------------------------------------------------------
// Decimal text to int64 fold multiplier
// Scales the running value by a power of ten modulo 2^64 with one shared
// 32x32 multiplier over three steps.
// ----------------------------------------------------------------------------
`default_nettype none

module dtoi_fold (
   input  wire logic                    clock,
   input  wire dtoi_pkg::fold_ctrl_type ctrl,
   input  wire logic [63:0]             mul_a,
   input  wire logic [63:0]             mul_b,
   output logic [63:0]                  product
);

   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] pp_ff, pp_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] op_x;
   logic [31:0] op_y;
   logic [63:0] prod_full;

   // Step 0 forms low*low, steps 1 and 2 the cross terms (low halves only).
   assign op_x      = ctrl.step1 ? a_ff[63:32] : a_ff[31:0];
   assign op_y      = ctrl.step2 ? b_ff[63:32] : b_ff[31:0];
   assign prod_full = 64'(op_x) * 64'(op_y);

   always_comb begin
      a_in   = ctrl.load_ops ? mul_a : a_ff;
      b_in   = ctrl.load_ops ? mul_b : b_ff;
      pp_in  = (ctrl.step0 || ctrl.step1 || ctrl.step2) ? prod_full : pp_ff;
      acc_in = acc_ff;
      if (ctrl.step1) begin
         acc_in = pp_ff;
      end else if (ctrl.step2) begin
         acc_in = acc_ff + {pp_ff[31:0], 32'd0};
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      pp_ff  <= pp_in;
      acc_ff <= acc_in;
   end

   assign product = acc_ff + {pp_ff[31:0], 32'd0};

endmodule

`default_nettype wire

[src/decimal_text_to_int64_unit.sv]
// ----------------------------------------------------------------------------
// Decimal text to int64 unit
// Streaming decimal text parser: folds 16-byte chunks into a 64-bit value
// and issues one result per number.
// ----------------------------------------------------------------------------
// A chunk that continues or opens a number passes, from its transfer until the
// next chunk can be taken, through a scan state in which all byte lanes look
// for the first non-digit at once, the multiply states MUL0, MUL1 and MUL2 on
// the shared 32x32 multiplier that scales the running value by ten to the power
// of the digits kept from this chunk (the lane adder tree completes in the
// same states), a finishing state that adds the chunk value and forms the
// result, and the idle state in which the next chunk is taken. A chunk that
// arrives while no number is open goes from the scan state straight back to
// idle, and a starting chunk with an empty buffer goes from the scan state
// straight to the finishing state. The finishing state waits only while the
// result register still holds an earlier result that has not been taken; the
// result register otherwise lets the next chunk in while the previous result
// is waiting. The mode register may be written only while the unit is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_text_to_int64_unit #(
   parameter int CHUNK_BYTES = 16,
   parameter int MAX_DIGITS  = 19
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire dtoi_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output dtoi_pkg::rsp_type      rsp_data,
   input  wire logic              csr_write_en,
   input  wire logic [1:0]        csr_write_data
);

   localparam int PW = dtoi_pkg::POS_W;
   localparam logic [PW-1:0] CHUNK_LEN = PW'(CHUNK_BYTES);
   localparam logic [PW-1:0] MAX_LEN   = PW'(MAX_DIGITS);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_SCAN = 6'b000010,
      ST_MUL0 = 6'b000100,
      ST_MUL1 = 6'b001000,
      ST_MUL2 = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   dtoi_pkg::req_type  chunk_ff, chunk_in;
   logic               open_ff, open_in;
   logic [1:0]         mode_ff, mode_in;
   logic [63:0]        running_ff, running_in;
   logic [PW-1:0]      count_ff, count_in;
   logic [15:0]        spill_ff, spill_in;
   logic               neg_ff, neg_in;
   logic [PW-1:0]      first_ff, first_in;
   logic [PW-1:0]      kept_ff, kept_in;
   logic [PW-1:0]      used_ff, used_in;
   logic               end_ff, end_in;
   logic               empty_ff, empty_in;
   dtoi_pkg::rsp_type  rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Scan-cycle signals.
   logic [127:0]       chunk_bytes;
   logic               start;
   logic [PW-1:0]      scan_n;
   logic               minus;
   logic [PW-1:0]      scan_first;
   logic [PW-1:0]      stop_pos;
   logic [PW-1:0]      digits;
   logic [PW-1:0]      room;
   logic [PW-1:0]      kept;
   logic [63:0]        running_eff;
   logic [PW-1:0]      count_eff;
   logic [15:0]        spill_eff;
   logic [16:0]        spill_wide;
   logic [15:0]        spill_sat;

   logic [CHUNK_BYTES-1:0]         lane_ok;
   logic [CHUNK_BYTES-1:0][63:0]   lane_terms;
   dtoi_pkg::lane_ctrl_type        lane_ctrl;
   dtoi_pkg::merge_ctrl_type       merge_ctrl;
   dtoi_pkg::fold_ctrl_type        fold_ctrl;
   logic [63:0]                    merge_sum;
   logic [63:0]                    fold_product;

   // Finishing-cycle signals.
   logic [63:0]          folded;
   dtoi_pkg::status_type status_sel;
   logic [63:0]          value_sel;
   logic                 need_out;
   logic                 rsp_free;

   assign chunk_bytes = {chunk_ff.chars_high, chunk_ff.chars_low};
   assign start       = chunk_ff.starts_number;
   assign scan_n      = (chunk_ff.valid_count > CHUNK_LEN) ? CHUNK_LEN
                                                          : chunk_ff.valid_count;

   // A minus sign counts only in signed mode and only as byte 0 of a start.
   assign minus = start && (mode_ff == dtoi_pkg::MODE_SIGNED) && (scan_n != '0) &&
                  (chunk_bytes[7:0] == dtoi_pkg::ASCII_MINUS);
   assign scan_first = minus ? PW'(1) : '0;

   // A new number starts from a cleared state.
   assign running_eff = start ? 64'd0 : running_ff;
   assign count_eff   = start ? '0 : count_ff;
   assign spill_eff   = start ? 16'd0 : spill_ff;

   // First position that stops the scan; a full chunk of digits gives CHUNK_LEN.
   always_comb begin
      stop_pos = CHUNK_LEN;
      for (int i = CHUNK_BYTES - 1; i >= 0; i--) begin
         if (!lane_ok[i]) begin
            stop_pos = PW'(i);
         end
      end
   end

   // Digits up to the limit are kept, the rest only add to the spill count.
   assign digits     = stop_pos - scan_first;
   assign room       = MAX_LEN - count_eff;
   assign kept       = (digits < room) ? digits : room;
   assign spill_wide = {1'b0, spill_eff} + 17'(digits - kept);
   assign spill_sat  = spill_wide[16] ? dtoi_pkg::SPILL_MAX : spill_wide[15:0];

   assign lane_ctrl.load_term  = (state_ff == ST_MUL0);
   assign lane_ctrl.scan_n     = scan_n;
   assign lane_ctrl.scan_first = scan_first;
   assign lane_ctrl.term_first = first_ff;
   assign lane_ctrl.term_kept  = kept_ff;

   assign merge_ctrl.load_part = (state_ff == ST_MUL1);
   assign merge_ctrl.load_sum  = (state_ff == ST_MUL2);

   assign fold_ctrl.load_ops = (state_ff == ST_SCAN);
   assign fold_ctrl.step0    = (state_ff == ST_MUL0);
   assign fold_ctrl.step1    = (state_ff == ST_MUL1);
   assign fold_ctrl.step2    = (state_ff == ST_MUL2);

   for (genvar i = 0; i < CHUNK_BYTES; i++) begin : g_lane
      dtoi_lane #(
         .LANE (i)
      ) u_lane (
         .clock (clock),
         .chr   (chunk_bytes[8*i +: 8]),
         .ctrl  (lane_ctrl),
         .ok    (lane_ok[i]),
         .term  (lane_terms[i])
      );
   end

   dtoi_merge #(
      .CHUNK_BYTES (CHUNK_BYTES)
   ) u_merge (
      .clock (clock),
      .ctrl  (merge_ctrl),
      .terms (lane_terms),
      .sum   (merge_sum)
   );

   dtoi_fold u_fold (
      .clock   (clock),
      .ctrl    (fold_ctrl),
      .mul_a   (running_eff),
      .mul_b   (dtoi_pkg::pow10(kept)),
      .product (fold_product)
   );

   // The running value after this chunk: scaled old value plus chunk digits.
   assign folded = fold_product + merge_sum;

   // Status of a finished number; the mode at the end of the number decides,
   // and mode 3 behaves as the strict unsigned mode.
   always_comb begin
      status_sel = dtoi_pkg::STATUS_OK;
      value_sel  = folded;
      if (empty_ff) begin
         status_sel = dtoi_pkg::STATUS_EMPTY;
      end else if ((count_ff == '0) && (spill_ff == 16'd0)) begin
         status_sel = dtoi_pkg::STATUS_NO_DIGITS;
      end else if (mode_ff == dtoi_pkg::MODE_SPILL) begin
         status_sel = dtoi_pkg::STATUS_OK;
      end else if (spill_ff != 16'd0) begin
         status_sel = dtoi_pkg::STATUS_TOO_MANY;
      end else if (mode_ff == dtoi_pkg::MODE_SIGNED) begin
         if (!neg_ff) begin
            if (folded[63]) begin
               status_sel = dtoi_pkg::STATUS_OVERFLOW;
            end
         end else if (folded[63] && (folded[62:0] != 63'd0)) begin
            status_sel = dtoi_pkg::STATUS_OVERFLOW;
         end else begin
            value_sel = ~folded + 64'd1;
         end
      end
   end

   assign need_out = empty_ff || end_ff;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      chunk_in     = chunk_ff;
      open_in      = open_ff;
      mode_in      = csr_write_en ? csr_write_data : mode_ff;
      running_in   = running_ff;
      count_in     = count_ff;
      spill_in     = spill_ff;
      neg_in       = neg_ff;
      first_in     = first_ff;
      kept_in      = kept_ff;
      used_in      = used_ff;
      end_in       = end_ff;
      empty_in     = empty_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               chunk_in = req_data;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!start && !open_ff) begin
               // Chunk outside any number: dropped.
               state_in = ST_IDLE;
            end else if (start && (scan_n == '0)) begin
               empty_in   = 1'b1;
               open_in    = 1'b0;
               running_in = 64'd0;
               count_in   = '0;
               spill_in   = 16'd0;
               neg_in     = 1'b0;
               state_in   = ST_DONE;
            end else begin
               empty_in   = 1'b0;
               open_in    = 1'b1;
               running_in = running_eff;
               count_in   = count_eff + kept;
               spill_in   = spill_sat;
               neg_in     = start ? minus : neg_ff;
               first_in   = scan_first;
               kept_in    = kept;
               used_in    = stop_pos;
               end_in     = (stop_pos != CHUNK_LEN);
               state_in   = ST_MUL0;
            end
         end
         ST_MUL0: begin
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!need_out || rsp_free) begin
               state_in = ST_IDLE;
               if (!empty_ff) begin
                  running_in = folded;
               end
               if (need_out) begin
                  open_in               = 1'b0;
                  rsp_valid_in          = 1'b1;
                  rsp_in.value          = (status_sel == dtoi_pkg::STATUS_OK) ? value_sel
                                                                              : 64'd0;
                  rsp_in.dropped_digits = spill_ff;
                  rsp_in.chars_used     = empty_ff ? 5'd0 : used_ff;
                  rsp_in.status         = status_sel;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         open_ff      <= 1'b0;
         mode_ff      <= dtoi_pkg::MODE_SPILL;
         running_ff   <= 64'd0;
         count_ff     <= '0;
         spill_ff     <= 16'd0;
         neg_ff       <= 1'b0;
         end_ff       <= 1'b0;
         empty_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         open_ff      <= open_in;
         mode_ff      <= mode_in;
         running_ff   <= running_in;
         count_ff     <= count_in;
         spill_ff     <= spill_in;
         neg_ff       <= neg_in;
         end_ff       <= end_in;
         empty_ff     <= empty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chunk_ff <= chunk_in;
      first_ff <= first_in;
      kept_ff  <= kept_in;
      used_ff  <= used_in;
      rsp_ff   <= rsp_in;
   end

   // No chunk is taken while reset is held.
   assign req_stall = reset || (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The kept digit count never passes its limit.
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_LEN)
      else $error("digit count above limit");

   // Digits spill only once the kept digits are full.
   a_spill_full: assert property (@(posedge clock) disable iff (reset)
      (spill_ff != 16'd0) |-> (count_ff == MAX_LEN))
      else $error("spill counted before digit limit reached");

   // A new result appears only out of the finishing cycle.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result loaded outside finishing cycle");

   // A finished number waits while the result register is still occupied.
   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && need_out && rsp_valid_ff && rsp_stall)
      |=> ((state_ff == ST_DONE) && $stable(rsp_ff)))
      else $error("pending result overwritten");

endmodule

`default_nettype wire
